// ----- rtl/rfp_pkg.sv -----
package rfp_pkg;

	localparam int unsigned FuncW   = 2;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned StatusW = 2;
	localparam int unsigned TicksW  = 16;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 16;

	localparam logic [FuncW-1:0] FUNC_ARM  = 2'd0;
	localparam logic [FuncW-1:0] FUNC_BYTE = 2'd1;
	localparam logic [FuncW-1:0] FUNC_TICK = 2'd2;

	localparam logic [StatusW-1:0] ST_OK      = 2'd0;
	localparam logic [StatusW-1:0] ST_TIMEOUT = 2'd1;
	localparam logic [StatusW-1:0] ST_INVALID = 2'd2;
	localparam logic [StatusW-1:0] ST_NOSPACE = 2'd3;

	localparam logic [CfgIdxW-1:0] REG_REQUEST_COMMAND  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_RESPONSE_TFI     = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_PAYLOAD_CAPACITY = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_TIMEOUT_TICKS    = 2'd3;

	localparam logic [ByteW-1:0]  RESET_REQUEST_COMMAND  = 8'd0;
	localparam logic [ByteW-1:0]  RESET_RESPONSE_TFI     = 8'd213;
	localparam logic [ByteW-1:0]  RESET_PAYLOAD_CAPACITY = 8'd255;
	localparam logic [TicksW-1:0] RESET_TIMEOUT_TICKS    = 16'd0;

	localparam logic [ByteW-1:0]  START_MARK   = 8'hFF;
	localparam logic [ByteW-1:0]  LEN_OVERHEAD = 8'd2;
	localparam logic [TicksW-1:0] TICKS_MAX    = 16'hFFFF;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_LENGTH,
		PH_HEADER,
		PH_PAYLOAD,
		PH_TRAILER
	} rfp_phase_t;

	typedef struct packed {
		logic [ByteW-1:0]  request_command;
		logic [ByteW-1:0]  response_tfi;
		logic [ByteW-1:0]  payload_capacity;
		logic [TicksW-1:0] timeout_ticks;
	} rfp_cfg_t;

	typedef struct packed {
		logic               out_kind;
		logic [ByteW-1:0]   payload_byte;
		logic [ByteW-1:0]   payload_index;
		logic [StatusW-1:0] status;
		logic [ByteW-1:0]   payload_length;
		logic               last;
	} rfp_result_t;

endpackage

// ----- rtl/rfp_if.sv -----
interface rfp_in_if;
	logic                           valid;
	logic                           ready;
	logic [rfp_pkg::FuncW-1:0]      func;
	logic [rfp_pkg::ByteW-1:0]      rx_byte;

	modport source(output valid, output func, output rx_byte, input ready);
	modport sink(input valid, input func, input rx_byte, output ready);
endinterface

interface rfp_out_if;
	logic                           valid;
	logic                           ready;
	logic                           out_kind;
	logic [rfp_pkg::ByteW-1:0]      payload_byte;
	logic [rfp_pkg::ByteW-1:0]      payload_index;
	logic [rfp_pkg::StatusW-1:0]    status;
	logic [rfp_pkg::ByteW-1:0]      payload_length;
	logic                           last;

	modport source(output valid, output out_kind, output payload_byte, output payload_index,
		output status, output payload_length, output last, input ready);
	modport sink(input valid, input out_kind, input payload_byte, input payload_index,
		input status, input payload_length, input last, output ready);
endinterface

// ----- rtl/rfp_cfg_regs.sv -----
module rfp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rfp_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [rfp_pkg::CfgDataW-1:0]  cfg_data,
	output rfp_pkg::rfp_cfg_t             cfg
);

	rfp_pkg::rfp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.request_command  <= rfp_pkg::RESET_REQUEST_COMMAND;
			cfg_q.response_tfi     <= rfp_pkg::RESET_RESPONSE_TFI;
			cfg_q.payload_capacity <= rfp_pkg::RESET_PAYLOAD_CAPACITY;
			cfg_q.timeout_ticks    <= rfp_pkg::RESET_TIMEOUT_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rfp_pkg::REG_REQUEST_COMMAND:
					cfg_q.request_command <= cfg_data[rfp_pkg::ByteW-1:0];
				rfp_pkg::REG_RESPONSE_TFI:
					cfg_q.response_tfi <= cfg_data[rfp_pkg::ByteW-1:0];
				rfp_pkg::REG_PAYLOAD_CAPACITY:
					cfg_q.payload_capacity <= cfg_data[rfp_pkg::ByteW-1:0];
				rfp_pkg::REG_TIMEOUT_TICKS:
					cfg_q.timeout_ticks <= cfg_data[rfp_pkg::TicksW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/rfp_parser.sv -----
module rfp_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step_en,
	input  logic [rfp_pkg::FuncW-1:0]   func,
	input  logic [rfp_pkg::ByteW-1:0]   rx_byte,
	input  rfp_pkg::rfp_cfg_t           cfg,
	output logic                        res_valid,
	output rfp_pkg::rfp_result_t        res
);

	rfp_pkg::rfp_phase_t          phase_q, phase_d;
	logic [rfp_pkg::ByteW-1:0]    byte_count_q, byte_count_d;
	logic [rfp_pkg::ByteW-1:0]    frame_length_q, frame_length_d;
	logic [rfp_pkg::ByteW-1:0]    running_sum_q, running_sum_d;
	logic [rfp_pkg::TicksW-1:0]   idle_ticks_q, idle_ticks_d;
	logic                         checksum_ok_q, checksum_ok_d;

	logic                         fin;
	logic [rfp_pkg::StatusW-1:0]  fin_status;
	logic                         emit_byte;

	logic [rfp_pkg::ByteW-1:0]    count_inc;
	logic [rfp_pkg::ByteW-1:0]    len_minus;
	logic [rfp_pkg::ByteW-1:0]    sum_plus;
	logic [rfp_pkg::ByteW-1:0]    expected_cmd;
	logic [rfp_pkg::ByteW-1:0]    start_expect;
	logic [rfp_pkg::TicksW-1:0]   ticks_inc;

	assign count_inc    = byte_count_q + 8'd1;
	assign len_minus    = frame_length_q - rfp_pkg::LEN_OVERHEAD;
	assign sum_plus     = running_sum_q + rx_byte;
	assign expected_cmd = cfg.request_command + 8'd1;
	assign start_expect = (byte_count_q == 8'd2) ? rfp_pkg::START_MARK : 8'd0;
	assign ticks_inc    = (idle_ticks_q < rfp_pkg::TICKS_MAX) ? idle_ticks_q + 16'd1
		: idle_ticks_q;

	// next state and completion decisions
	always_comb begin
		phase_d        = phase_q;
		byte_count_d   = byte_count_q;
		frame_length_d = frame_length_q;
		running_sum_d  = running_sum_q;
		idle_ticks_d   = idle_ticks_q;
		checksum_ok_d  = checksum_ok_q;
		fin            = 1'b0;
		fin_status     = rfp_pkg::ST_OK;
		emit_byte      = 1'b0;

		if (func == rfp_pkg::FUNC_ARM) begin
			phase_d        = rfp_pkg::PH_START;
			byte_count_d   = '0;
			checksum_ok_d  = 1'b1;
			frame_length_d = '0;
			running_sum_d  = '0;
			idle_ticks_d   = '0;
		end else if (phase_q != rfp_pkg::PH_IDLE && func == rfp_pkg::FUNC_BYTE) begin
			idle_ticks_d = '0;
			unique case (phase_q)
				rfp_pkg::PH_START: begin
					checksum_ok_d = checksum_ok_q && (rx_byte == start_expect);
					byte_count_d  = count_inc;
					if (count_inc == 8'd3) begin
						if (!checksum_ok_d) begin
							fin        = 1'b1;
							fin_status = rfp_pkg::ST_INVALID;
						end else begin
							phase_d      = rfp_pkg::PH_LENGTH;
							byte_count_d = '0;
						end
					end
				end
				rfp_pkg::PH_LENGTH: begin
					if (byte_count_q == 8'd0) begin
						frame_length_d = rx_byte;
						byte_count_d   = 8'd1;
					end else if (frame_length_q + rx_byte != 8'd0) begin
						fin        = 1'b1;
						fin_status = rfp_pkg::ST_INVALID;
					end else begin
						frame_length_d = len_minus;
						if (len_minus > cfg.payload_capacity) begin
							fin        = 1'b1;
							fin_status = rfp_pkg::ST_NOSPACE;
						end else begin
							phase_d       = rfp_pkg::PH_HEADER;
							byte_count_d  = '0;
							checksum_ok_d = 1'b1;
						end
					end
				end
				rfp_pkg::PH_HEADER: begin
					if (byte_count_q == 8'd0) begin
						checksum_ok_d = checksum_ok_q && (rx_byte == cfg.response_tfi);
						running_sum_d = rx_byte;
						byte_count_d  = 8'd1;
					end else begin
						checksum_ok_d = checksum_ok_q && (rx_byte == expected_cmd);
						running_sum_d = sum_plus;
						if (!checksum_ok_d) begin
							fin        = 1'b1;
							fin_status = rfp_pkg::ST_INVALID;
						end else begin
							byte_count_d = '0;
							phase_d      = (frame_length_q == 8'd0) ? rfp_pkg::PH_TRAILER
								: rfp_pkg::PH_PAYLOAD;
						end
					end
				end
				rfp_pkg::PH_PAYLOAD: begin
					emit_byte     = 1'b1;
					running_sum_d = sum_plus;
					if (count_inc == frame_length_q) begin
						phase_d       = rfp_pkg::PH_TRAILER;
						byte_count_d  = '0;
						checksum_ok_d = 1'b1;
					end else begin
						byte_count_d = count_inc;
					end
				end
				rfp_pkg::PH_TRAILER: begin
					if (byte_count_q == 8'd0) begin
						checksum_ok_d = (sum_plus == 8'd0);
						byte_count_d  = 8'd1;
					end else begin
						fin        = 1'b1;
						fin_status = (checksum_ok_q && rx_byte == 8'd0) ? rfp_pkg::ST_OK
							: rfp_pkg::ST_INVALID;
					end
				end
				default: ;
			endcase
		end else if (phase_q != rfp_pkg::PH_IDLE && func == rfp_pkg::FUNC_TICK
			&& cfg.timeout_ticks != '0) begin
			idle_ticks_d = ticks_inc;
			if (ticks_inc >= cfg.timeout_ticks) begin
				fin        = 1'b1;
				fin_status = rfp_pkg::ST_TIMEOUT;
			end
		end

		if (fin) begin
			phase_d       = rfp_pkg::PH_IDLE;
			byte_count_d  = '0;
			checksum_ok_d = 1'b0;
		end
	end

	// result fields
	always_comb begin
		res_valid          = fin || emit_byte;
		res.out_kind       = rfp_pkg::KIND_PAYLOAD;
		res.payload_byte   = '0;
		res.payload_index  = '0;
		res.status         = rfp_pkg::ST_OK;
		res.payload_length = '0;
		res.last           = 1'b0;
		if (fin) begin
			res.out_kind       = rfp_pkg::KIND_STATUS;
			res.status         = fin_status;
			res.payload_length = (fin_status == rfp_pkg::ST_OK) ? frame_length_q : '0;
			res.last           = 1'b1;
		end else if (emit_byte) begin
			res.payload_byte  = rx_byte;
			res.payload_index = byte_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= rfp_pkg::PH_IDLE;
			byte_count_q   <= '0;
			frame_length_q <= '0;
			running_sum_q  <= '0;
			idle_ticks_q   <= '0;
			checksum_ok_q  <= 1'b0;
		end else if (step_en) begin
			phase_q        <= phase_d;
			byte_count_q   <= byte_count_d;
			frame_length_q <= frame_length_d;
			running_sum_q  <= running_sum_d;
			idle_ticks_q   <= idle_ticks_d;
			checksum_ok_q  <= checksum_ok_d;
		end
	end

	a_fin_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && fin |=> phase_q == rfp_pkg::PH_IDLE)
		else $error("completion did not return parser to idle");

	a_payload_in_phase: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && emit_byte |-> phase_q == rfp_pkg::PH_PAYLOAD && func == rfp_pkg::FUNC_BYTE)
		else $error("payload result outside payload phase");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == rfp_pkg::PH_PAYLOAD |-> byte_count_q < frame_length_q)
		else $error("payload index reached frame length");

endmodule

// ----- rtl/response_frame_parser.sv -----
// path: the transfer loads an accepted item into the input register; the result register
// loads its result when free or being emptied, and drives res_out
// items that cause no result just pass
// throughput: one item per cycle while the result side takes results
// reset: arst_n clears the parser to idle (not armed) and loads register defaults
module response_frame_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	rfp_in_if.sink                        rx_in,
	rfp_out_if.source                     res_out,
	input  logic                          cfg_we,
	input  logic [rfp_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [rfp_pkg::CfgDataW-1:0]  cfg_data
);

	rfp_pkg::rfp_cfg_t           cfg;
	logic                        valid_s1;
	logic [rfp_pkg::FuncW-1:0]   func_s1;
	logic [rfp_pkg::ByteW-1:0]   rx_byte_s1;
	logic                        advance;
	logic                        res_valid;
	rfp_pkg::rfp_result_t        res;
	logic                        out_valid_q;
	rfp_pkg::rfp_result_t        out_res_q;

	rfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the stage moves whenever the result register is free or being emptied
	assign advance     = !out_valid_q || res_out.ready;
	assign rx_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_in.ready) begin
			valid_s1 <= rx_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_in.ready && rx_in.valid) begin
			func_s1    <= rx_in.func;
			rx_byte_s1 <= rx_in.rx_byte;
		end
	end

	rfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (valid_s1 && advance),
		.func      (func_s1),
		.rx_byte   (rx_byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			out_res_q <= res;
		end
	end

	assign res_out.valid          = out_valid_q;
	assign res_out.out_kind       = out_res_q.out_kind;
	assign res_out.payload_byte   = out_res_q.payload_byte;
	assign res_out.payload_index  = out_res_q.payload_index;
	assign res_out.status         = out_res_q.status;
	assign res_out.payload_length = out_res_q.payload_length;
	assign res_out.last           = out_res_q.last;

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(func_s1) && $stable(rx_byte_s1))
		else $error("input stage lost an item while stalled");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_res_q.last == out_res_q.out_kind)
		else $error("last flag disagrees with result kind");

	a_no_ready_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !res_out.ready |-> !rx_in.ready)
		else $error("input taken while both stages were blocked");

endmodule
